/* hw/rtl/ddao_pkg.sv */
// Package for the differential-drive arc odometry core.
// Holds widths, the CORDIC arctangent table and the shared types.
// No dependencies.
package ddao_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int STEP_W       = $clog2(TABLE_LEN + 1);

	localparam logic [15:0] CPT_RESET = 16'd21299;
	localparam logic [15:0] WB_RESET  = 16'd2708;

	localparam logic [0:0] REG_CPT = 1'b0;
	localparam logic [0:0] REG_WB  = 1'b1;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
	localparam logic [17:0] RAD_TO_BA = 18'd166886;

	localparam logic signed [41:0] R_LIMIT = 42'sd1099511627775;

	function automatic logic signed [33:0] atan_lut(input logic [STEP_W-1:0] i);
		case (i)
			5'd0:  atan_lut = 34'sd536870912;
			5'd1:  atan_lut = 34'sd316933406;
			5'd2:  atan_lut = 34'sd167458907;
			5'd3:  atan_lut = 34'sd85004756;
			5'd4:  atan_lut = 34'sd42667331;
			5'd5:  atan_lut = 34'sd21354465;
			5'd6:  atan_lut = 34'sd10679838;
			5'd7:  atan_lut = 34'sd5340245;
			5'd8:  atan_lut = 34'sd2670163;
			5'd9:  atan_lut = 34'sd1335087;
			5'd10: atan_lut = 34'sd667544;
			5'd11: atan_lut = 34'sd333772;
			5'd12: atan_lut = 34'sd166886;
			5'd13: atan_lut = 34'sd83443;
			5'd14: atan_lut = 34'sd41722;
			5'd15: atan_lut = 34'sd20861;
			5'd16: atan_lut = 34'sd10430;
			5'd17: atan_lut = 34'sd5215;
			5'd18: atan_lut = 34'sd2608;
			5'd19: atan_lut = 34'sd1304;
			5'd20: atan_lut = 34'sd652;
			5'd21: atan_lut = 34'sd326;
			5'd22: atan_lut = 34'sd163;
			5'd23: atan_lut = 34'sd81;
			default: atan_lut = 34'sd0;
		endcase
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) sat24 = 24'sd8388607;
		else if (v < -64'sd8388608) sat24 = -24'sd8388608;
		else sat24 = v[23:0];
	endfunction

	typedef struct packed {
		logic start;
		logic [15:0] angle;
	} trig_req_t;

	typedef struct packed {
		logic done;
		logic signed [16:0] cos_v;
		logic signed [16:0] sin_v;
	} trig_rsp_t;

	typedef struct packed {
		logic start;
		logic sign_n;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

/* hw/rtl/diff_drive_arc_odometry_core.sv */
// Differential-drive arc odometry core.
// A turn uses the 64-step serial divider twice and the CORDIC twice;
// a straight request uses each of them once.
// One request at a time; in_stall stays high until the result is taken.
// Asynchronous reset clears heading to zero and loads register defaults.
// Uses ddao_pkg, ddao_cordic, ddao_divider.
module diff_drive_arc_odometry_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] left_ticks,
	input  logic signed [15:0] right_ticks,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] delta_x,
	output logic signed [23:0] delta_y,
	output logic signed [15:0] heading_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import ddao_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_MUL   = 11'b00000000010,
		ST_DIVD  = 11'b00000000100,
		ST_WAITD = 11'b00000001000,
		ST_DIVR  = 11'b00000010000,
		ST_WAITR = 11'b00000100000,
		ST_TRIG1 = 11'b00001000000,
		ST_WAIT1 = 11'b00010000000,
		ST_WAIT2 = 11'b00100000000,
		ST_FIN   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	state_t st_q;
	logic [15:0] cpt_q, wb_q, head_q, h2_q;
	logic signed [15:0] lt_q, rt_q;
	logic signed [34:0] diff_q, sum_q;
	logic signed [41:0] r_q;
	logic signed [15:0] d_q;
	logic signed [16:0] c1_q, s1_q;
	logic signed [23:0] dx_q, dy_q;
	logic straight_q, sel_q;

	trig_req_t treq;
	trig_rsp_t trsp;
	div_req_t dreq;
	div_rsp_t drsp;

	ddao_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(treq), .rsp(trsp));
	ddao_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [15:0] wb_eff;
	logic [63:0] dq_abs;
	logic signed [63:0] num_d, num_r, den_r, pa, pb;
	logic signed [17:0] tdx, tdy;

	always_comb begin
		wb_eff = (wb_q == 16'd0) ? 16'd1 : wb_q;
		num_d  = 64'(diff_q) * $signed({1'b0, RAD_TO_BA});
		num_r  = 64'(sum_q) * $signed({1'b0, wb_eff});
		den_r  = 64'(diff_q) <<< 1;
		dq_abs = drsp.quo;
		treq.start = (st_q == ST_TRIG1) || (st_q == ST_WAIT1 && trsp.done && !straight_q);
		treq.angle = (st_q == ST_TRIG1) ? head_q : h2_q;
		dreq.start = (st_q == ST_DIVD) || (st_q == ST_DIVR);
		if (st_q == ST_DIVD) begin
			dreq.sign_n = num_d[63];
			dreq.num = num_d[63] ? 64'(-num_d) : 64'(num_d);
			dreq.den = {36'd0, wb_eff, 12'd0};
		end else begin
			dreq.sign_n = num_r[63] ^ den_r[63];
			dreq.num = num_r[63] ? 64'(-num_r) : 64'(num_r);
			dreq.den = den_r[63] ? 64'(-den_r) : 64'(den_r);
		end
		tdx = 18'(c1_q) - 18'(trsp.cos_v);
		tdy = 18'(trsp.sin_v) - 18'(s1_q);
		if (straight_q) begin
			pa = 64'(sum_q) * 64'(sel_q ? c1_q : s1_q);
			pb = 64'(sum_q) * 64'(c1_q);
		end else begin
			pa = 64'(r_q) * 64'(tdx);
			pb = 64'(r_q) * 64'(tdy);
		end
	end

	function automatic logic signed [63:0] tdiv(input logic signed [63:0] v,
		input int sh);
		logic signed [63:0] a;
		a = v[63] ? -v : v;
		a = a >>> sh;
		tdiv = v[63] ? -a : a;
	endfunction

	assign cfg_ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			head_q <= '0;
			cpt_q  <= CPT_RESET;
			wb_q   <= WB_RESET;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == REG_CPT) cpt_q <= cfg_data;
						else if (cfg_index == REG_WB) wb_q <= cfg_data;
					end
					if (in_valid) begin
						lt_q <= left_ticks;
						rt_q <= right_ticks;
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					diff_q <= (35'(lt_q) - 35'(rt_q)) * 35'($signed({1'b0, cpt_q}));
					sum_q  <= (35'(lt_q) + 35'(rt_q)) * 35'($signed({1'b0, cpt_q}));
					st_q <= ST_DIVD;
				end
				ST_DIVD: st_q <= ST_WAITD;
				ST_WAITD: if (drsp.done) begin
					d_q <= dq_abs[15:0];
					straight_q <= (dq_abs == 64'd0);
					h2_q <= head_q + dq_abs[15:0];
					st_q <= (dq_abs == 64'd0) ? ST_TRIG1 : ST_DIVR;
				end
				ST_DIVR: st_q <= ST_WAITR;
				ST_WAITR: if (drsp.done) begin
					if ($signed(drsp.quo) > 64'(R_LIMIT)) r_q <= R_LIMIT;
					else if ($signed(drsp.quo) < -64'(R_LIMIT)) r_q <= -R_LIMIT;
					else r_q <= drsp.quo[41:0];
					st_q <= ST_TRIG1;
				end
				ST_TRIG1: st_q <= ST_WAIT1;
				ST_WAIT1: if (trsp.done) begin
					c1_q <= trsp.cos_v;
					s1_q <= trsp.sin_v;
					sel_q <= 1'b0;
					st_q <= straight_q ? ST_FIN : ST_WAIT2;
				end
				ST_WAIT2: if (trsp.done) begin
					dx_q <= sat24(tdiv(pa, 14));
					dy_q <= sat24(tdiv(pb, 14));
					head_q <= h2_q;
					st_q <= ST_OUT;
				end
				ST_FIN: begin
					if (!sel_q) begin
						dx_q <= sat24(tdiv(pa, 23));
						sel_q <= 1'b1;
					end else begin
						dy_q <= sat24(tdiv(pa, 23));
						st_q <= ST_OUT;
					end
				end
				ST_OUT: if (!out_stall) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = (st_q != ST_IDLE);
	assign out_valid   = (st_q == ST_OUT);
	assign delta_x     = dx_q;
	assign delta_y     = dy_q;
	assign heading_out = head_q;

	a_out_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
	a_heading_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |=> $stable(head_q)) else $error("heading moved on output");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_unused_d: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WAIT2) |-> !straight_q && (d_q != 16'd0 || h2_q == head_q))
		else $error("turn path without heading change");
endmodule

/* hw/rtl/ddao_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation a cycle.
// Gives cos and sin of a binary angle rounded to Q1.14. Uses ddao_pkg.
module ddao_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  ddao_pkg::trig_req_t req,
	output ddao_pkg::trig_rsp_t rsp
);
	import ddao_pkg::*;

	logic signed [35:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [STEP_W-1:0] i_q;
	logic busy_q, neg_q, done_q;
	logic signed [16:0] c_q, s_q;

	logic signed [16:0] a0, a1;
	logic n1;
	logic signed [35:0] xs, ys, xr, yr;

	always_comb begin
		a0 = {req.angle[15], req.angle};
		n1 = 1'b0;
		a1 = a0;
		if (a0 > 17'sd16384) begin
			a1 = a0 - 17'sd32768; n1 = 1'b1;
		end else if (a0 < -17'sd16384) begin
			a1 = a0 + 17'sd32768; n1 = 1'b1;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		xr = (x_q + 36'sd32768) >>> 16;
		yr = (y_q + 36'sd32768) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				neg_q  <= n1;
				x_q    <= 36'(CORDIC_GAIN);
				y_q    <= '0;
				z_q    <= 34'(a1) <<< 16;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == STEP_W'(CORDIC_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					c_q <= neg_q ? -xr[16:0] : xr[16:0];
					s_q <= neg_q ? -yr[16:0] : yr[16:0];
				end else begin
					if (z_q >= 0) begin
						x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_lut(i_q);
					end else begin
						x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_lut(i_q);
					end
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = c_q;
	assign rsp.sin_v = s_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("cordic done while busy");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> i_q <= STEP_W'(CORDIC_STEPS)) else $error("cordic step overrun");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("cordic done held");
endmodule

/* hw/rtl/ddao_divider.sv */
// Restoring unsigned divider, one quotient bit a cycle, 64 bit operands.
// Truncating quotient with sign applied at the end. Uses ddao_pkg.
module ddao_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  ddao_pkg::div_req_t req,
	output ddao_pkg::div_rsp_t rsp
);
	import ddao_pkg::*;

	logic [63:0] q_q, d_q;
	logic [64:0] r_q;
	logic [6:0] n_q;
	logic busy_q, done_q, sg_q;
	logic [64:0] r_sh, r_sub;

	always_comb begin
		r_sh  = {r_q[63:0], q_q[63]};
		r_sub = r_sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				q_q <= req.num;
				d_q <= req.den;
				r_q <= '0;
				n_q <= '0;
				sg_q <= req.sign_n;
			end else if (busy_q) begin
				if (n_q == 7'd64) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (sg_q) q_q <= -q_q;
				end else begin
					if (!r_sub[64]) begin
						r_q <= r_sub; q_q <= {q_q[62:0], 1'b1};
					end else begin
						r_q <= r_sh;  q_q <= {q_q[62:0], 1'b0};
					end
					n_q <= n_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = q_q;
endmodule
